### hw/rtl/lcg_pkg.sv
// Package with widths and types shared by the line color gradient block.
`timescale 1ns / 1ps
`default_nettype none
package lcg_pkg;
	localparam int COORD_BITS = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = DIFF_BITS + 9;
	localparam int NUM_BITS   = COORD_BITS + 11;
	localparam int SPAN_BITS  = 16;
	localparam int COLOR_BITS = 24;
	localparam int CHAN_BITS  = 8;
	localparam int NUM_CHAN   = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [NUM_BITS-1:0]   num_t;
	typedef logic        [NUM_BITS-1:0]   mag_t;
	typedef logic        [DIFF_BITS-1:0]  dmag_t;
	typedef logic        [SPAN_BITS-1:0]  span_t;
	typedef logic        [COLOR_BITS-1:0] color_t;
	typedef logic        [CHAN_BITS-1:0]  chan_t;
endpackage
`default_nettype wire

### hw/rtl/lcg_if.sv
// Valid/ready channel interfaces for pixel requests and pixel colors.
`timescale 1ns / 1ps
`default_nettype none
interface lcg_in_if;
	import lcg_pkg::*;
	logic   valid;
	logic   ready;
	coord_t cur_x;
	coord_t cur_y;
	coord_t from_x;
	coord_t from_y;
	coord_t to_x;
	coord_t to_y;
	span_t  span_x;
	span_t  span_y;
	color_t from_color;
	color_t to_color;
	modport source (output valid, cur_x, cur_y, from_x, from_y, to_x, to_y,
		span_x, span_y, from_color, to_color, input ready);
	modport sink (input valid, cur_x, cur_y, from_x, from_y, to_x, to_y,
		span_x, span_y, from_color, to_color, output ready);
endinterface

interface lcg_out_if;
	import lcg_pkg::*;
	logic   valid;
	logic   ready;
	color_t pixel_color;
	modport source (output valid, pixel_color, input ready);
	modport sink (input valid, pixel_color, output ready);
endinterface
`default_nettype wire

### hw/rtl/line_color_gradient.sv
// Top level of the line color gradient: a seven-stage interpolation pipeline.
// Throughput is one transaction per cycle; the whole pipeline advances together,
// and it holds when the last stage carries a result that is not taken.
// The per-channel divide is a restoring divider spread two quotient bits per stage.
// Reset clears only the stage valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module line_color_gradient (
	input wire logic clk,
	input wire logic arst_n,
	lcg_in_if.sink   pix_in,
	lcg_out_if.source pix_out
);
	import lcg_pkg::*;

	// One enable for every stage: the pipeline moves unless a finished
	// result sits in the last stage waiting for the sink.
	logic en;

	// Stage 1: pick the major axis and form the signed differences.
	logic   v_s1, eq_s1;
	diff_t  d_s1, p_s1, dp_s1;
	color_t sc_s1, ec_s1;

	// Stage 2: the two products of each channel.
	logic   v_s2, eq_s2, zero_s2;
	diff_t  d_s2;
	color_t sc_s2, ec_s2;
	prod_t  ps_s2 [NUM_CHAN];
	prod_t  pe_s2 [NUM_CHAN];

	// Stage 3: magnitudes of numerator and denominator, and the quotient sign.
	logic   v_s3, eq_s3, zero_s3;
	color_t sc_s3, ec_s3;
	dmag_t  b_s3;
	mag_t   a_s3   [NUM_CHAN];
	logic   neg_s3 [NUM_CHAN];

	// Stages 4 to 7: two quotient bits per stage.
	logic   v_s4, eq_s4, zero_s4;
	color_t sc_s4, ec_s4;
	dmag_t  b_s4;
	mag_t   rem_s4 [NUM_CHAN];
	chan_t  q_s4   [NUM_CHAN];
	logic   neg_s4 [NUM_CHAN];
	logic   sat_s4 [NUM_CHAN];

	logic   v_s5, eq_s5, zero_s5;
	color_t sc_s5, ec_s5;
	dmag_t  b_s5;
	mag_t   rem_s5 [NUM_CHAN];
	chan_t  q_s5   [NUM_CHAN];
	logic   neg_s5 [NUM_CHAN];
	logic   sat_s5 [NUM_CHAN];

	logic   v_s6, eq_s6, zero_s6;
	color_t sc_s6, ec_s6;
	dmag_t  b_s6;
	mag_t   rem_s6 [NUM_CHAN];
	chan_t  q_s6   [NUM_CHAN];
	logic   neg_s6 [NUM_CHAN];
	logic   sat_s6 [NUM_CHAN];

	logic   v_s7;
	color_t pix_s7;

	// One restoring step: subtract the shifted divisor when it fits.
	// The top bit of the result is the quotient bit.
	function automatic logic [NUM_BITS:0] div_step(input mag_t rem, input dmag_t b,
			input int sh);
		logic [NUM_BITS:0] bs;
		logic [NUM_BITS:0] r;
		bs = (NUM_BITS+1)'(b) << sh;
		r  = {1'b0, rem};
		if (r >= bs) begin
			return {1'b1, NUM_BITS'(r - bs)};
		end
		return {1'b0, rem};
	endfunction

	assign en           = !v_s7 || pix_out.ready;
	assign pix_in.ready = en;
	assign pix_out.valid = v_s7;
	assign pix_out.pixel_color = pix_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1.
	coord_t cur_sel, from_sel, to_sel;
	always_comb begin
		if (pix_in.span_x > pix_in.span_y) begin
			cur_sel  = pix_in.cur_x;
			from_sel = pix_in.from_x;
			to_sel   = pix_in.to_x;
		end else begin
			cur_sel  = pix_in.cur_y;
			from_sel = pix_in.from_y;
			to_sel   = pix_in.to_y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= DIFF_BITS'(to_sel) - DIFF_BITS'(from_sel);
			p_s1  <= DIFF_BITS'(cur_sel) - DIFF_BITS'(from_sel);
			dp_s1 <= DIFF_BITS'(to_sel) - DIFF_BITS'(cur_sel);
			sc_s1 <= pix_in.from_color;
			ec_s1 <= pix_in.to_color;
			eq_s1 <= (pix_in.from_color == pix_in.to_color);
		end
	end

	// Stage 2: s*(d-p) and e*p for each channel.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2    <= d_s1;
			zero_s2 <= (d_s1 == '0);
			eq_s2   <= eq_s1;
			sc_s2   <= sc_s1;
			ec_s2   <= ec_s1;
			for (int c = 0; c < NUM_CHAN; c++) begin
				ps_s2[c] <= $signed({1'b0, sc_s1[c*CHAN_BITS +: CHAN_BITS]}) * dp_s1;
				pe_s2[c] <= $signed({1'b0, ec_s1[c*CHAN_BITS +: CHAN_BITS]}) * p_s1;
			end
		end
	end

	// Stage 3: a truncating signed divide becomes an unsigned divide of the
	// magnitudes; when the signs differ the clamped result is always zero.
	num_t num_c [NUM_CHAN];
	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			num_c[c] = NUM_BITS'(ps_s2[c]) + NUM_BITS'(pe_s2[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eq_s3   <= eq_s2;
			zero_s3 <= zero_s2;
			sc_s3   <= sc_s2;
			ec_s3   <= ec_s2;
			b_s3    <= d_s2[DIFF_BITS-1] ? dmag_t'(-d_s2) : dmag_t'(d_s2);
			for (int c = 0; c < NUM_CHAN; c++) begin
				a_s3[c]   <= num_c[c][NUM_BITS-1] ? mag_t'(-num_c[c]) : mag_t'(num_c[c]);
				neg_s3[c] <= num_c[c][NUM_BITS-1] ^ d_s2[DIFF_BITS-1];
			end
		end
	end

	// Stage 4: saturation test and quotient bits 7 and 6.
	logic [NUM_BITS:0] st4a [NUM_CHAN];
	logic [NUM_BITS:0] st4b [NUM_CHAN];
	logic [NUM_BITS:0] st5a [NUM_CHAN];
	logic [NUM_BITS:0] st5b [NUM_CHAN];
	logic [NUM_BITS:0] st6a [NUM_CHAN];
	logic [NUM_BITS:0] st6b [NUM_CHAN];
	logic [NUM_BITS:0] st7a [NUM_CHAN];
	logic [NUM_BITS:0] st7b [NUM_CHAN];
	chan_t             ch7  [NUM_CHAN];
	color_t            mix7;

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			st4a[c] = div_step(a_s3[c], b_s3, 7);
			st4b[c] = div_step(st4a[c][NUM_BITS-1:0], b_s3, 6);
			st5a[c] = div_step(rem_s4[c], b_s4, 5);
			st5b[c] = div_step(st5a[c][NUM_BITS-1:0], b_s4, 4);
			st6a[c] = div_step(rem_s5[c], b_s5, 3);
			st6b[c] = div_step(st6a[c][NUM_BITS-1:0], b_s5, 2);
			st7a[c] = div_step(rem_s6[c], b_s6, 1);
			st7b[c] = div_step(st7a[c][NUM_BITS-1:0], b_s6, 0);
			if (neg_s6[c]) begin
				ch7[c] = '0;
			end else if (sat_s6[c]) begin
				ch7[c] = '1;
			end else begin
				ch7[c] = {q_s6[c][7:2], st7a[c][NUM_BITS], st7b[c][NUM_BITS]};
			end
			mix7[c*CHAN_BITS +: CHAN_BITS] = ch7[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eq_s4   <= eq_s3;
			zero_s4 <= zero_s3;
			sc_s4   <= sc_s3;
			ec_s4   <= ec_s3;
			b_s4    <= b_s3;
			for (int c = 0; c < NUM_CHAN; c++) begin
				sat_s4[c] <= ({1'b0, a_s3[c]} >= ((NUM_BITS+1)'(b_s3) << CHAN_BITS));
				neg_s4[c] <= neg_s3[c];
				rem_s4[c] <= st4b[c][NUM_BITS-1:0];
				q_s4[c]   <= {st4a[c][NUM_BITS], st4b[c][NUM_BITS], 6'b0};
			end

			eq_s5   <= eq_s4;
			zero_s5 <= zero_s4;
			sc_s5   <= sc_s4;
			ec_s5   <= ec_s4;
			b_s5    <= b_s4;
			for (int c = 0; c < NUM_CHAN; c++) begin
				sat_s5[c] <= sat_s4[c];
				neg_s5[c] <= neg_s4[c];
				rem_s5[c] <= st5b[c][NUM_BITS-1:0];
				q_s5[c]   <= {q_s4[c][7:6], st5a[c][NUM_BITS], st5b[c][NUM_BITS], 4'b0};
			end

			eq_s6   <= eq_s5;
			zero_s6 <= zero_s5;
			sc_s6   <= sc_s5;
			ec_s6   <= ec_s5;
			b_s6    <= b_s5;
			for (int c = 0; c < NUM_CHAN; c++) begin
				sat_s6[c] <= sat_s5[c];
				neg_s6[c] <= neg_s5[c];
				rem_s6[c] <= st6b[c][NUM_BITS-1:0];
				q_s6[c]   <= {q_s5[c][7:4], st6a[c][NUM_BITS], st6b[c][NUM_BITS], 2'b0};
			end

			// Equal colors win over a zero span, which wins over the blend.
			if (eq_s6) begin
				pix_s7 <= sc_s6;
			end else if (zero_s6) begin
				pix_s7 <= ec_s6;
			end else begin
				pix_s7 <= mix7;
			end
		end
	end
endmodule
`default_nettype wire
